// ===== sv/ptte_pkg.sv =====
// Shared types, register codes and the rounding blend for the
// pulse transit time estimator. No dependencies.
package ptte_pkg;

  localparam int CONF_W    = 11;
  localparam int RATE_W    = 16;
  localparam int TIME_W    = 32;
  localparam int TRN_W     = 19;
  localparam int WGT_W     = 9;
  localparam int NODE_W    = 8;
  localparam int REFR_W    = 21;
  localparam int MAXD_W    = 22;
  localparam int REG_IDX_W = 3;
  localparam int CFG_DATA_W = 22;
  localparam int ACC_W     = TRN_W + WGT_W + 1;

  // register indexes on the config channel
  localparam logic [REG_IDX_W-1:0] REG_RATE_CONF  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAIR_CONF  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RATE_WGT   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TRN_WGT    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_REFRACTORY = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MAX_DELAY  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TRN_MIN    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_TRN_MAX    = 3'd7;

  localparam logic [NODE_W-1:0] ARM_NODE_ID   = 8'd1;
  localparam logic [TRN_W-1:0]  TRANSIT_RESET = 19'd200000;
  localparam logic [WGT_W-1:0]  WGT_FULL      = 9'd256;

  // beat state after the front stage, handed to the transit stage
  typedef struct packed {
    logic              accepted;
    logic [CONF_W-1:0] arm_conf;
    logic [CONF_W-1:0] finger_conf;
    logic [TIME_W-1:0] arm_beat;
    logic [TIME_W-1:0] finger_beat;
  } ptte_mid_t;

  typedef struct packed {
    logic [CONF_W-1:0] pair_conf_thr;
    logic [WGT_W-1:0]  weight;
    logic [TRN_W-1:0]  min_us;
    logic [TRN_W-1:0]  max_us;
  } ptte_trn_cfg_t;

  // (fresh*w + old*(256-w) + 128) >> 8, weight saturated at 256
  function automatic logic [TRN_W-1:0] blend(input logic [TRN_W-1:0] fresh,
                                             input logic [TRN_W-1:0] old,
                                             input logic [WGT_W-1:0] w);
    logic [WGT_W-1:0] ws;
    logic [ACC_W-1:0] acc;
    ws  = (w > WGT_FULL) ? WGT_FULL : w;
    acc = (ACC_W'(fresh) * ACC_W'(ws)) + (ACC_W'(old) * ACC_W'(WGT_FULL - ws))
        + ACC_W'(128);
    return acc[TRN_W+7:8];
  endfunction

endpackage

// ===== sv/ptte_ifs.sv =====
// Valid/ready channel interfaces of the pulse transit time estimator:
// report input, result output and register write. Depends on ptte_pkg.
interface ptte_in_if import ptte_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] node_id;
  logic [RATE_W-1:0] rate_in;
  logic [TIME_W-1:0] processing_delay_us;
  logic [CONF_W-1:0] confidence_in;
  logic [TIME_W-1:0] arrival_time_us;

  modport source (output valid, node_id, rate_in, processing_delay_us, confidence_in,
                  arrival_time_us, input ready);
  modport sink   (input valid, node_id, rate_in, processing_delay_us, confidence_in,
                  arrival_time_us, output ready);
endinterface

interface ptte_out_if import ptte_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TRN_W-1:0]  transit_time_us;
  logic [RATE_W-1:0] arm_rate;
  logic [RATE_W-1:0] finger_rate;
  logic              beat_accepted;
  logic              transit_updated;

  modport source (output valid, transit_time_us, arm_rate, finger_rate, beat_accepted,
                  transit_updated, input ready);
  modport sink   (input valid, transit_time_us, arm_rate, finger_rate, beat_accepted,
                  transit_updated, output ready);
endinterface

interface ptte_cfg_if import ptte_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/ptte_transit.sv =====
// Transit stage: qualifies the arm-to-finger interval and keeps the
// smoothed transit time. Depends on ptte_pkg.
module ptte_transit import ptte_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  ptte_mid_t        mid_i,
  input  ptte_trn_cfg_t    cfg_i,
  output logic [TRN_W-1:0] transit_o,
  output logic             updated_o
);

  logic [TRN_W-1:0]  avg_q, avg_d;
  logic              upd_q, upd_d;
  logic [TIME_W-1:0] diff;
  logic              pair_ok, win_ok;

  always_comb begin
    diff    = mid_i.finger_beat - mid_i.arm_beat;
    pair_ok = mid_i.accepted
            && (mid_i.arm_conf > cfg_i.pair_conf_thr)
            && (mid_i.finger_conf > cfg_i.pair_conf_thr)
            && (mid_i.finger_beat > mid_i.arm_beat);
    win_ok  = (diff > TIME_W'(cfg_i.min_us)) && (diff < TIME_W'(cfg_i.max_us));
    upd_d   = pair_ok && win_ok;
    // diff is below max_us here, so it fits the transit width
    avg_d   = upd_d ? blend(diff[TRN_W-1:0], avg_q, cfg_i.weight) : avg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= TRANSIT_RESET;
      upd_q <= 1'b0;
    end else if (fire_i) begin
      avg_q <= avg_d;
      upd_q <= upd_d;
    end
  end

  assign transit_o = avg_q;
  assign updated_o = upd_q;

endmodule

// ===== sv/pulse_transit_time_estimator.sv =====
// Top level of the pulse transit time estimator: register file, input and
// beat stages, output register. Depends on ptte_pkg, ptte_ifs, ptte_transit.
//
// Each transfer on in_i is one beat report; node id 1 is the arm sensor, any
// other id the finger sensor. The report's confidence is stored for its node,
// and its heart rate is folded into that node's rounded exponential average
// when the confidence exceeds rate_conf_threshold. A delay strictly between 0
// and max_delay_us back-dates the beat to arrival minus delay; the beat is
// taken when it lies beyond the node's last beat plus refractory_us (32-bit
// unsigned compare, timestamps wrap). After a taken beat with both stored
// confidences above pair_conf_threshold and the finger beat later than the arm
// beat, an interval strictly inside (transit_min_us, transit_max_us) is folded
// into the transit average, which starts at 200000 us. Every report yields
// exactly one result on out_o showing the state after that report. The block
// is three register stages deep (input register, beat/rate stage, transit
// stage feeding the output register): the input register captures a report
// at its transfer, the beat/rate and transit stages register it in turn, and one
// report is taken every cycle; a stage holds only while the stage after it is
// full and cannot move on, so a waiting result only stops the input once all
// three stages are occupied. Register writes on cfg_i are always ready and
// take effect on the next cycle; write them only while no report is in flight.
module pulse_transit_time_estimator import ptte_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  ptte_in_if.sink    in_i,
  ptte_out_if.source out_o,
  ptte_cfg_if.sink   cfg_i
);

  // ---------------- register file ----------------
  logic [CONF_W-1:0] rate_conf_thr_q, pair_conf_thr_q;
  logic [WGT_W-1:0]  rate_wgt_q, trn_wgt_q;
  logic [REFR_W-1:0] refractory_q;
  logic [MAXD_W-1:0] max_delay_q;
  logic [TRN_W-1:0]  trn_min_q, trn_max_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_conf_thr_q <= 11'd205;
      pair_conf_thr_q <= 11'd819;
      rate_wgt_q      <= 9'd77;
      trn_wgt_q       <= 9'd51;
      refractory_q    <= 21'd300000;
      max_delay_q     <= 22'd2000000;
      trn_min_q       <= 19'd50000;
      trn_max_q       <= 19'd400000;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_RATE_CONF:  rate_conf_thr_q <= cfg_i.data[CONF_W-1:0];
        REG_PAIR_CONF:  pair_conf_thr_q <= cfg_i.data[CONF_W-1:0];
        REG_RATE_WGT:   rate_wgt_q      <= cfg_i.data[WGT_W-1:0];
        REG_TRN_WGT:    trn_wgt_q       <= cfg_i.data[WGT_W-1:0];
        REG_REFRACTORY: refractory_q    <= cfg_i.data[REFR_W-1:0];
        REG_MAX_DELAY:  max_delay_q     <= cfg_i.data[MAXD_W-1:0];
        REG_TRN_MIN:    trn_min_q       <= cfg_i.data[TRN_W-1:0];
        REG_TRN_MAX:    trn_max_q       <= cfg_i.data[TRN_W-1:0];
        default:        ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // v0: input register, v1: beat stage output, v2: result register
  logic v0_q, v1_q, v2_q;
  logic ready0, ready1, ready2;
  logic in_fire, fire_a, fire_b;

  assign ready2     = !v2_q || out_o.ready;
  assign ready1     = !v1_q || ready2;
  assign ready0     = !v0_q || ready1;
  assign in_i.ready = ready0;
  assign in_fire    = in_i.valid && ready0;
  assign fire_a     = v0_q && ready1;
  assign fire_b     = v1_q && ready2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ready0) v0_q <= in_i.valid;
      if (ready1) v1_q <= v0_q;
      if (ready2) v2_q <= v1_q;
    end
  end

  // ---------------- input register ----------------
  logic [NODE_W-1:0] node_q;
  logic [RATE_W-1:0] rate_q;
  logic [TIME_W-1:0] delay_q, now_q;
  logic [CONF_W-1:0] conf_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      node_q  <= in_i.node_id;
      rate_q  <= in_i.rate_in;
      delay_q <= in_i.processing_delay_us;
      conf_q  <= in_i.confidence_in;
      now_q   <= in_i.arrival_time_us;
    end
  end

  // ---------------- beat / rate stage ----------------
  logic [RATE_W-1:0] arm_rate_q, finger_rate_q, arm_rate_d, finger_rate_d;
  logic [CONF_W-1:0] arm_conf_q, finger_conf_q, arm_conf_d, finger_conf_d;
  logic [TIME_W-1:0] arm_beat_q, finger_beat_q, arm_beat_d, finger_beat_d;
  logic              is_arm, rate_upd, delay_ok, accepted;
  logic [TIME_W-1:0] beat_evt, beat_last, beat_limit;
  logic [RATE_W-1:0] rate_old, rate_new;
  logic [TRN_W-1:0]  rate_blend;

  always_comb begin
    is_arm     = (node_q == ARM_NODE_ID);
    rate_old   = is_arm ? arm_rate_q : finger_rate_q;
    beat_last  = is_arm ? arm_beat_q : finger_beat_q;
    rate_upd   = conf_q > rate_conf_thr_q;
    rate_blend = blend(TRN_W'(rate_q), TRN_W'(rate_old), rate_wgt_q);
    rate_new   = rate_upd ? rate_blend[RATE_W-1:0] : rate_old;

    delay_ok   = (delay_q != '0) && (delay_q < TIME_W'(max_delay_q));
    beat_evt   = now_q - delay_q;
    beat_limit = beat_last + TIME_W'(refractory_q);  // wraps like the timestamps
    accepted   = delay_ok && (beat_evt > beat_limit);

    arm_rate_d    = arm_rate_q;
    finger_rate_d = finger_rate_q;
    arm_conf_d    = arm_conf_q;
    finger_conf_d = finger_conf_q;
    arm_beat_d    = arm_beat_q;
    finger_beat_d = finger_beat_q;
    if (is_arm) begin
      arm_rate_d = rate_new;
      arm_conf_d = conf_q;
      if (accepted) arm_beat_d = beat_evt;
    end else begin
      finger_rate_d = rate_new;
      finger_conf_d = conf_q;
      if (accepted) finger_beat_d = beat_evt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_rate_q    <= '0;
      finger_rate_q <= '0;
      arm_conf_q    <= '0;
      finger_conf_q <= '0;
      arm_beat_q    <= '0;
      finger_beat_q <= '0;
    end else if (fire_a) begin
      arm_rate_q    <= arm_rate_d;
      finger_rate_q <= finger_rate_d;
      arm_conf_q    <= arm_conf_d;
      finger_conf_q <= finger_conf_d;
      arm_beat_q    <= arm_beat_d;
      finger_beat_q <= finger_beat_d;
    end
  end

  // snapshot for the transit stage; rates ride along to the result
  ptte_mid_t         mid_q;
  logic [RATE_W-1:0] mid_arm_rate_q, mid_finger_rate_q;

  always_ff @(posedge clk_i) begin
    if (fire_a) begin
      mid_q.accepted    <= accepted;
      mid_q.arm_conf    <= arm_conf_d;
      mid_q.finger_conf <= finger_conf_d;
      mid_q.arm_beat    <= arm_beat_d;
      mid_q.finger_beat <= finger_beat_d;
      mid_arm_rate_q    <= arm_rate_d;
      mid_finger_rate_q <= finger_rate_d;
    end
  end

  // ---------------- transit stage / result register ----------------
  ptte_trn_cfg_t    trn_cfg;
  logic [TRN_W-1:0] transit_avg;
  logic             transit_upd;

  assign trn_cfg.pair_conf_thr = pair_conf_thr_q;
  assign trn_cfg.weight        = trn_wgt_q;
  assign trn_cfg.min_us        = trn_min_q;
  assign trn_cfg.max_us        = trn_max_q;

  ptte_transit u_transit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire_b),
    .mid_i     (mid_q),
    .cfg_i     (trn_cfg),
    .transit_o (transit_avg),
    .updated_o (transit_upd)
  );

  logic [RATE_W-1:0] out_arm_rate_q, out_finger_rate_q;
  logic              out_accepted_q;

  always_ff @(posedge clk_i) begin
    if (fire_b) begin
      out_arm_rate_q    <= mid_arm_rate_q;
      out_finger_rate_q <= mid_finger_rate_q;
      out_accepted_q    <= mid_q.accepted;
    end
  end

  assign out_o.valid           = v2_q;
  assign out_o.transit_time_us = transit_avg;
  assign out_o.arm_rate        = out_arm_rate_q;
  assign out_o.finger_rate     = out_finger_rate_q;
  assign out_o.beat_accepted   = out_accepted_q;
  assign out_o.transit_updated = transit_upd;

`ifndef SYNTHESIS
  // a transit update only ever follows a taken beat
  a_upd_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.transit_updated |-> out_o.beat_accepted)
    else $error("transit updated without an accepted beat");

  // beat times move only when the beat stage fires
  a_beat_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_a |=> $stable(arm_beat_q) && $stable(finger_beat_q))
    else $error("beat time changed without a transfer through the beat stage");

  // one report touches one node's beat only
  a_one_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_a |=> $stable(arm_beat_q) || $stable(finger_beat_q))
    else $error("both beat times changed on one report");

  // transit average holds while the transit stage is stalled or empty
  a_transit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_b |=> $stable(transit_avg))
    else $error("transit average changed without a transfer");
`endif

endmodule
